// ----- hw/rtl/equal_power_crossfade_handoff_top_macros.svh -----
// Assertion macros shared by the crossfade handoff RTL.
`ifndef EQUAL_POWER_CROSSFADE_HANDOFF_TOP_MACROS_SVH
`define EQUAL_POWER_CROSSFADE_HANDOFF_TOP_MACROS_SVH
`ifndef SYNTH
`define EPCH_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("implication check failed");
`define EPCH_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define EPCH_ASSERT_IMP(label, clk, rstn, a, c)
`define EPCH_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

// ----- hw/rtl/epch_pkg.sv -----
// Package with the codes, constants and types of the crossfade handoff block.
`timescale 1ns / 1ps
package epch_pkg;
    localparam logic [2:0] MODE_STOP     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_BEGIN    = 3'd2;
    localparam logic [2:0] MODE_PREPARE  = 3'd3;
    localparam logic [2:0] MODE_PROCESS  = 3'd4;
    localparam logic [2:0] MODE_COMMIT   = 3'd5;
    localparam logic [2:0] MODE_ROLLBACK = 3'd6;

    localparam logic [2:0] PH_UNBOUND   = 3'd0;
    localparam logic [2:0] PH_SYNCED    = 3'd1;
    localparam logic [2:0] PH_PREPARING = 3'd2;
    localparam logic [2:0] PH_FADING    = 3'd3;
    localparam logic [2:0] PH_READY     = 3'd4;
    localparam logic [2:0] PH_ROLLED    = 3'd5;
    localparam logic [2:0] PH_DEGRADED  = 3'd6;

    localparam logic [1:0] ROUTE_NONE   = 2'd0;
    localparam logic [1:0] ROUTE_ACTIVE = 2'd1;
    localparam logic [1:0] ROUTE_BOTH   = 2'd2;

    localparam logic [16:0] FADE_MAX  = 17'd131071;
    localparam logic [16:0] P_MAX     = 17'd65536;
    localparam logic [30:0] Q30_ONE   = 31'd1073741824;

    // Division by 1000 as a multiplication by ceil(2^38 / 1000) and a shift by 38.
    localparam logic [28:0] DIV1000_MUL = 29'd274877907;

    localparam logic [30:0] SIN_C0 = 31'd1686629713;
    localparam logic [30:0] SIN_C1 = 31'd693598668;
    localparam logic [30:0] SIN_C2 = 31'd85569306;
    localparam logic [30:0] SIN_C3 = 31'd5026995;
    localparam logic [30:0] SIN_C4 = 31'd172272;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [16:0] divisor;
    } div_req_t;
endpackage

// ----- hw/rtl/equal_power_crossfade_handoff_top.sv -----
// Top level of the equal-power crossfade handoff controller.
//
//  Channel | Direction | Handshake          | Contents
//  s_      | in        | s_valid / s_ready  | command and worker responses
//  m_      | out       | m_valid / m_ready  | status, gains, routing, stop actions
//
// Commands without arithmetic pass from evaluation through the finish state to the output.
// A granted begin adds a step for the multiplication by the reciprocal of 1000.
// A faded block runs the 33-bit restoring divider and, if the candidate accepts, two sines
// (new gain, then old gain) on the shared multiplier before its result is presented.
// Reset is synchronous and clears the handoff state to unbound on slot 0.
// s_ready is high only while no item is in work; a stalled result waits in
// the output register while the next transfer is taken.
`timescale 1ns / 1ps
`include "equal_power_crossfade_handoff_top_macros.svh"
module equal_power_crossfade_handoff_top #(
    parameter int MAX_FADE_MS    = 200,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic        s_start_ok,
    input  logic [5:0]  s_channel_count,
    input  logic [18:0] s_sample_rate,
    input  logic [18:0] s_active_sample_rate,
    input  logic [15:0] s_frame_count,
    input  logic [7:0]  s_fade_ms,
    input  logic [1:0]  s_active_status,
    input  logic [2:0]  s_candidate_status,
    input  logic        s_candidate_accept,
    input  logic        s_active_accept,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [2:0]  m_handoff_state,
    output logic        m_active_slot_out,
    output logic [16:0] m_fade_done,
    output logic [16:0] m_fade_total,
    output logic [15:0] m_old_gain,
    output logic [15:0] m_new_gain,
    output logic [1:0]  m_route,
    output logic        m_stop_candidate,
    output logic        m_stop_active
);
    localparam logic [7:0] MAX_FMS = 8'(MAX_FADE_MS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EVAL    = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_SIN_NEW = 3'd3;
    localparam logic [2:0] ST_SIN_OLD = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;
    localparam logic [2:0] ST_TOT     = 3'd6;

    logic [2:0]  st_reg, st_next;
    logic [2:0]  phase_reg, phase_next;
    logic        slot_reg, slot_next;
    logic [5:0]  bound_reg, bound_next;
    logic [16:0] ff_reg, ff_next;
    logic [16:0] ftf_reg, ftf_next;
    logic        res_ok_reg, res_ok_next;
    logic [1:0]  res_route_reg, res_route_next;
    logic        res_sc_reg, res_sc_next;
    logic        res_sa_reg, res_sa_next;
    logic [15:0] res_go_reg, res_go_next;
    logic [15:0] res_gn_reg, res_gn_next;
    logic [30:0] x_reg, x_next;
    logic        m_valid_reg, m_valid_next;
    logic [26:0] rate_ms_reg, rate_ms_next;

    logic [2:0]  in_mode_reg;
    logic        in_sok_reg;
    logic [5:0]  in_ch_reg;
    logic [18:0] in_rate_reg, in_arate_reg;
    logic [15:0] in_frames_reg;
    logic [7:0]  in_fms_reg;
    logic [1:0]  in_ast_reg;
    logic [2:0]  in_cst_reg;
    logic        in_cacc_reg, in_aacc_reg;

    logic        m_ok_reg;
    logic [2:0]  m_state_reg;
    logic        m_slot_reg;
    logic [16:0] m_done_reg, m_total_reg;
    logic [15:0] m_go_reg, m_gn_reg;
    logic [1:0]  m_route_reg;
    logic        m_sc_reg, m_sa_reg;

    epch_pkg::div_req_t div_req;
    logic        div_done;
    logic [32:0] div_q;
    logic        sin_start;
    logic [30:0] sin_x;
    logic        sin_done;
    logic [15:0] sin_gain;

    logic        accept;
    logic        begin_ok;
    logic [55:0] tot_prod;
    logic [16:0] tot_q;
    logic [16:0] tot_lo;
    logic [16:0] prog;
    logic [17:0] done_sum;
    logic [16:0] done_sat;
    logic        plain_res;
    logic        gains_zero;

    epch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    epch_sine #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_sine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sin_start),
        .x       (sin_x),
        .done    (sin_done),
        .gain    (sin_gain)
    );

    assign s_ready = (st_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign begin_ok = (phase_reg == epch_pkg::PH_SYNCED || phase_reg == epch_pkg::PH_ROLLED)
                      && in_ast_reg[0] && (in_fms_reg != 8'd0) && (in_fms_reg <= MAX_FMS)
                      && (in_ch_reg == bound_reg) && (in_rate_reg != 19'd0)
                      && (in_rate_reg == in_arate_reg);
    assign rate_ms_next = 27'(in_rate_reg) * 27'(in_fms_reg);
    assign tot_prod = 56'(rate_ms_reg) * 56'(epch_pkg::DIV1000_MUL);
    assign tot_q    = tot_prod[54:38];
    assign tot_lo   = (tot_q < {1'b0, in_frames_reg}) ? {1'b0, in_frames_reg} : tot_q;
    assign prog     = (div_q > 33'(epch_pkg::P_MAX)) ? epch_pkg::P_MAX : div_q[16:0];
    assign done_sum = {1'b0, ff_reg} + {2'b00, in_frames_reg};
    assign done_sat = (done_sum > {1'b0, ftf_reg}) ? ftf_reg : done_sum[16:0];

    always_comb begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        bound_next     = bound_reg;
        ff_next        = ff_reg;
        ftf_next       = ftf_reg;
        res_ok_next    = res_ok_reg;
        res_route_next = res_route_reg;
        res_sc_next    = res_sc_reg;
        res_sa_next    = res_sa_reg;
        res_go_next    = res_go_reg;
        res_gn_next    = res_gn_reg;
        x_next         = x_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        div_req.start    = 1'b0;
        div_req.dividend = {ff_reg, 16'd0};
        div_req.divisor  = ftf_reg;
        sin_start      = 1'b0;
        sin_x          = {prog, 14'd0};
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_ok_next    = 1'b0;
                res_route_next = epch_pkg::ROUTE_NONE;
                res_sc_next    = 1'b0;
                res_sa_next    = 1'b0;
                res_go_next    = 16'd0;
                res_gn_next    = 16'd0;
                st_next        = ST_FIN;
                unique case (in_mode_reg)
                    epch_pkg::MODE_STOP, epch_pkg::MODE_START: begin
                        phase_next  = epch_pkg::PH_UNBOUND;
                        slot_next   = 1'b0;
                        bound_next  = 6'd0;
                        ff_next     = 17'd0;
                        ftf_next    = 17'd0;
                        res_sc_next = 1'b1;
                        res_sa_next = 1'b1;
                        res_ok_next = 1'b1;
                        if (in_mode_reg == epch_pkg::MODE_START) begin
                            if (in_sok_reg) begin
                                bound_next = in_ch_reg;
                                phase_next = epch_pkg::PH_SYNCED;
                            end else begin
                                phase_next  = epch_pkg::PH_DEGRADED;
                                res_ok_next = 1'b0;
                            end
                        end
                    end
                    epch_pkg::MODE_BEGIN: begin
                        if (begin_ok) begin
                            res_sc_next = 1'b1;
                            if (!in_sok_reg) begin
                                phase_next = epch_pkg::PH_DEGRADED;
                            end else begin
                                st_next = ST_TOT;
                            end
                        end
                    end
                    epch_pkg::MODE_PREPARE: begin
                        if (phase_reg == epch_pkg::PH_PREPARING) begin
                            if (in_cst_reg[0]) begin
                                phase_next  = epch_pkg::PH_FADING;
                                res_ok_next = 1'b1;
                            end else if (!in_cst_reg[1] && in_cst_reg[2]) begin
                                res_sc_next = 1'b1;
                                phase_next  = epch_pkg::PH_ROLLED;
                            end
                        end
                    end
                    epch_pkg::MODE_PROCESS: begin
                        if (phase_reg == epch_pkg::PH_SYNCED) begin
                            res_route_next = epch_pkg::ROUTE_ACTIVE;
                            res_ok_next    = in_aacc_reg;
                        end else if (phase_reg == epch_pkg::PH_FADING && ftf_reg != 17'd0) begin
                            div_req.start = 1'b1;
                            st_next       = ST_DIV;
                        end
                    end
                    epch_pkg::MODE_COMMIT: begin
                        if (phase_reg == epch_pkg::PH_READY) begin
                            res_sa_next = 1'b1;
                            slot_next   = ~slot_reg;
                            ff_next     = 17'd0;
                            ftf_next    = 17'd0;
                            phase_next  = epch_pkg::PH_SYNCED;
                            res_ok_next = 1'b1;
                        end
                    end
                    epch_pkg::MODE_ROLLBACK: begin
                        if (phase_reg == epch_pkg::PH_PREPARING ||
                            phase_reg == epch_pkg::PH_FADING ||
                            phase_reg == epch_pkg::PH_READY) begin
                            res_sc_next = 1'b1;
                            ff_next     = 17'd0;
                            ftf_next    = 17'd0;
                            phase_next  = in_ast_reg[1] ? epch_pkg::PH_ROLLED
                                                        : epch_pkg::PH_DEGRADED;
                            res_ok_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TOT: begin
                ftf_next    = tot_lo;
                ff_next     = 17'd0;
                phase_next  = epch_pkg::PH_PREPARING;
                res_ok_next = 1'b1;
                st_next     = ST_FIN;
            end
            ST_DIV: begin
                if (div_done) begin
                    st_next = ST_FIN;
                    if (!in_cacc_reg) begin
                        res_sc_next    = 1'b1;
                        phase_next     = epch_pkg::PH_ROLLED;
                        res_route_next = epch_pkg::ROUTE_ACTIVE;
                        res_ok_next    = in_aacc_reg;
                    end else begin
                        x_next    = {prog, 14'd0};
                        sin_start = 1'b1;
                        st_next   = ST_SIN_NEW;
                    end
                end
            end
            ST_SIN_NEW: begin
                sin_x = epch_pkg::Q30_ONE - x_reg;
                if (sin_done) begin
                    res_gn_next = sin_gain;
                    sin_start   = 1'b1;
                    st_next     = ST_SIN_OLD;
                end
            end
            ST_SIN_OLD: begin
                if (sin_done) begin
                    res_go_next    = sin_gain;
                    res_route_next = epch_pkg::ROUTE_BOTH;
                    st_next        = ST_FIN;
                    if (!in_aacc_reg) begin
                        res_sc_next = 1'b1;
                        phase_next  = epch_pkg::PH_DEGRADED;
                    end else begin
                        ff_next     = done_sat;
                        res_ok_next = 1'b1;
                        if (done_sat >= ftf_reg) begin
                            phase_next = epch_pkg::PH_READY;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            phase_reg     <= epch_pkg::PH_UNBOUND;
            slot_reg      <= 1'b0;
            bound_reg     <= 6'd0;
            ff_reg        <= 17'd0;
            ftf_reg       <= 17'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            bound_reg     <= bound_next;
            ff_reg        <= ff_next;
            ftf_reg       <= ftf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_ok_reg    <= res_ok_next;
        res_route_reg <= res_route_next;
        res_sc_reg    <= res_sc_next;
        res_sa_reg    <= res_sa_next;
        res_go_reg    <= res_go_next;
        res_gn_reg    <= res_gn_next;
        x_reg         <= x_next;
        rate_ms_reg   <= rate_ms_next;
        if (accept) begin
            in_mode_reg   <= s_mode;
            in_sok_reg    <= s_start_ok;
            in_ch_reg     <= s_channel_count;
            in_rate_reg   <= s_sample_rate;
            in_arate_reg  <= s_active_sample_rate;
            in_frames_reg <= s_frame_count;
            in_fms_reg    <= s_fade_ms;
            in_ast_reg    <= s_active_status;
            in_cst_reg    <= s_candidate_status;
            in_cacc_reg   <= s_candidate_accept;
            in_aacc_reg   <= s_active_accept;
        end
        if (st_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_ok_reg    <= res_ok_reg;
            m_state_reg <= phase_reg;
            m_slot_reg  <= slot_reg;
            m_done_reg  <= ff_reg;
            m_total_reg <= ftf_reg;
            m_go_reg    <= res_go_reg;
            m_gn_reg    <= res_gn_reg;
            m_route_reg <= res_route_reg;
            m_sc_reg    <= res_sc_reg;
            m_sa_reg    <= res_sa_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_handoff_state   = m_state_reg;
    assign m_active_slot_out = m_slot_reg;
    assign m_fade_done       = m_done_reg;
    assign m_fade_total      = m_total_reg;
    assign m_old_gain        = m_go_reg;
    assign m_new_gain        = m_gn_reg;
    assign m_route           = m_route_reg;
    assign m_stop_candidate  = m_sc_reg;
    assign m_stop_active     = m_sa_reg;

    assign plain_res  = m_valid && (m_route != epch_pkg::ROUTE_BOTH);
    assign gains_zero = (m_old_gain == 16'd0) && (m_new_gain == 16'd0);

    `EPCH_ASSERT_IMP(a_faded_le_total, aclk, aresetn, 1'b1, ff_reg <= ftf_reg)
    `EPCH_ASSERT_NEXT(a_accept_to_eval, aclk, aresetn, accept, st_reg == ST_EVAL)
    `EPCH_ASSERT_IMP(a_gains_need_route, aclk, aresetn, plain_res, gains_zero)
    `EPCH_ASSERT_IMP(a_sine_in_sine_state, aclk, aresetn, sin_done, st_reg == ST_SIN_NEW || st_reg == ST_SIN_OLD)
endmodule

// ----- hw/rtl/epch_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module epch_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  epch_pkg::div_req_t req,
    output logic              done,
    output logic [32:0]       quotient
);
    localparam logic [5:0] N_BITS = 6'd33;

    logic [32:0] dvd_reg;
    logic [16:0] dvs_reg;
    logic [17:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg[16:0], dvd_reg[32]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= N_BITS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= 18'd0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            dvd_reg <= {dvd_reg[31:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

// ----- hw/rtl/epch_sine.sv -----
// Quarter-wave sine evaluator built around one shared multiplier.
`timescale 1ns / 1ps
module epch_sine #(
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] x,
    output logic        done,
    output logic [15:0] gain
);
    localparam logic [63:0] RND = 64'd1 << (59 - GAIN_FRAC_BITS);
    localparam logic [63:0] ONE = 64'd1 << GAIN_FRAC_BITS;
    localparam int          SH  = 60 - GAIN_FRAC_BITS;
    localparam logic [3:0]  LAST = 4'd9;

    logic [30:0] x_reg, x2_reg, x3_reg, x5_reg, x7_reg, x9_reg;
    logic [63:0] s_reg;
    logic [61:0] prod_reg;
    logic [3:0]  step_reg;
    logic        mph_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [30:0] op_a, op_b;
    logic [30:0] prod_q;
    logic [63:0] prod_w;
    logic [63:0] g64;

    always_comb begin
        unique case (step_reg)
            4'd0: begin op_a = x_reg;  op_b = x_reg;  end
            4'd1: begin op_a = x2_reg; op_b = x_reg;  end
            4'd2: begin op_a = x3_reg; op_b = x2_reg; end
            4'd3: begin op_a = x5_reg; op_b = x2_reg; end
            4'd4: begin op_a = x7_reg; op_b = x2_reg; end
            4'd5: begin op_a = epch_pkg::SIN_C0; op_b = x_reg;  end
            4'd6: begin op_a = epch_pkg::SIN_C1; op_b = x3_reg; end
            4'd7: begin op_a = epch_pkg::SIN_C2; op_b = x5_reg; end
            4'd8: begin op_a = epch_pkg::SIN_C3; op_b = x7_reg; end
            default: begin op_a = epch_pkg::SIN_C4; op_b = x9_reg; end
        endcase
    end

    assign prod_q = prod_reg[60:30];
    assign prod_w = {2'b00, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mph_reg  <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                mph_reg  <= 1'b0;
                step_reg <= 4'd0;
            end else if (busy_reg) begin
                mph_reg <= ~mph_reg;
                if (mph_reg) begin
                    if (step_reg == LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x;
        end else if (busy_reg && !mph_reg) begin
            prod_reg <= op_a * op_b;
        end else if (busy_reg) begin
            unique case (step_reg)
                4'd0: x2_reg <= prod_q;
                4'd1: x3_reg <= prod_q;
                4'd2: x5_reg <= prod_q;
                4'd3: x7_reg <= prod_q;
                4'd4: x9_reg <= prod_q;
                4'd5: s_reg  <= prod_w;
                4'd6: s_reg  <= s_reg - prod_w;
                4'd7: s_reg  <= s_reg + prod_w;
                4'd8: s_reg  <= s_reg - prod_w;
                default: s_reg <= s_reg + prod_w;
            endcase
        end
    end

    assign g64  = (s_reg + RND) >> SH;
    assign gain = (g64 > ONE) ? ONE[15:0] : g64[15:0];
    assign done = done_reg;
endmodule
